// File: rtl/mbtrr_pkg.sv
`default_nettype none
package mbtrr_pkg;

    typedef struct packed {
        logic        kind;
        logic [7:0]  request_byte;
        logic [5:0]  entry_slot;
        logic [7:0]  entry_unit;
        logic [2:0]  entry_function;
        logic [15:0] entry_address;
        logic [15:0] entry_value;
        logic [1:0]  entry_status;
    } t_req;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       response_last;
        logic       frame_dropped;
    } t_resp;

    typedef struct packed {
        logic [7:0]  unit;
        logic [2:0]  func;
        logic [15:0] addr;
        logic [15:0] value;
        logic [1:0]  status;
    } t_entry;

    // queued work for the back end
    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  slot;
        t_entry      entry;
        logic [15:0] trans;
        logic [7:0]  unit;
        logic [8:0]  len;
        logic [7:0]  func;
        logic [15:0] start;
        logic [15:0] cnt;
    } t_cmd;

    localparam logic [1:0] CMD_MAP  = 2'd0;
    localparam logic [1:0] CMD_REQ  = 2'd1;
    localparam logic [1:0] CMD_DROP = 2'd2;

    localparam int QDEPTH = 4;

    localparam logic [8:0] MAX_LENGTH = 9'd260;
    localparam logic [7:0] EXC_FLAG   = 8'h80;
    localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
    localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
    localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;
    localparam logic [7:0] EXC_DEVICE_FAILURE   = 8'h04;

    localparam logic [7:0] FN_READ_COILS    = 8'd1;
    localparam logic [7:0] FN_READ_INPUTS   = 8'd2;
    localparam logic [7:0] FN_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FN_READ_INPUT_RG = 8'd4;
    localparam logic [7:0] FN_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FN_WRITE_REG     = 8'd6;
    localparam logic [7:0] FN_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FN_WRITE_REGS    = 8'd16;

    localparam logic [1:0] CFG_WRITES_ENABLED = 2'd0;
    localparam logic [1:0] CFG_MAX_REGS       = 2'd1;
    localparam logic [1:0] CFG_MAX_BITS       = 2'd2;

endpackage
`default_nettype wire

// File: rtl/modbus_tcp_read_responder.sv
`default_nettype none
// Modbus TCP read responder.
// Input side is a queue write port: present an item on i_req and raise push
// while full is low. kind 0 carries one request byte, kind 1 loads one map
// entry. Items are taken at one per cycle while full is low; map loads and
// frame-ending or frame-dropping bytes enter a 4-deep command queue.
// Results come out as a queue read port: while empty is low, o_resp holds
// the oldest response byte; raise pop to take it. A good frame produces
// 7 + PDU bytes with response_last on the final one; a bad MBAP header
// produces one beat with frame_dropped set.
// Each address of a read walks the map table from slot 0, with a read and
// a compare state per slot, until the lowest matching slot; register
// reads add a low-byte write state per address; a missing address walks
// all min(MAP_ENTRIES, 64) slots. Each response beat is loaded in one
// state and shown in the next.
// The map walk sets the throughput; the front end keeps taking bytes
// until the command queue fills, then holds full high.
// Configuration writes (index 0..2) are taken every cycle (o_cfg_ready=1)
// and must happen while the block is idle.
// Reset (synchronous, active low) clears the parser, the queue, all map
// entries (to empty) and the config registers to 0 / 27 / 440.
// A stalled receiver simply holds the current beat; nothing is lost.
module modbus_tcp_read_responder
    import mbtrr_pkg::*;
#(
    parameter int MAP_ENTRIES = 64,
    parameter int REPLY_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire t_req       i_req,
    output logic            empty,
    input  wire logic       pop,
    output t_resp           o_resp,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [8:0] i_cfg_data
);

    localparam int SLOTS = (MAP_ENTRIES < 64) ? MAP_ENTRIES : 64;

    logic       r_writes_enabled;
    logic [4:0] r_max_regs;
    logic [8:0] r_max_bits;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_writes_enabled <= 1'b0;
            r_max_regs       <= 5'd27;
            r_max_bits       <= 9'd440;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WRITES_ENABLED: r_writes_enabled <= i_cfg_data[0];
                CFG_MAX_REGS:       r_max_regs       <= i_cfg_data[4:0];
                CFG_MAX_BITS:       r_max_bits       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic q_push, q_full, q_pop, q_empty;
    t_cmd f_cmd, q_cmd;

    assign full = q_full;

    mbtrr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (push && !q_full),
        .i_req    (i_req),
        .o_push   (q_push),
        .o_cmd    (f_cmd)
    );

    mbtrr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (q_cmd)
    );

    mbtrr_back #(
        .SLOTS       (SLOTS),
        .REPLY_BYTES (REPLY_BYTES)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_cmd            (q_cmd),
        .o_q_pop          (q_pop),
        .i_writes_enabled (r_writes_enabled),
        .i_max_regs       (r_max_regs),
        .i_max_bits       (r_max_bits),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_resp           (o_resp)
    );

endmodule
`default_nettype wire

// File: rtl/mbtrr_front.sv
`default_nettype none
module mbtrr_front
    import mbtrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_accept,
    input  wire t_req i_req,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [8:0]  r_pos, n_pos;
    logic [15:0] r_trans, n_trans;
    logic [7:0]  r_unit, n_unit;
    logic [8:0]  r_len, n_len;
    logic [7:0]  r_func, n_func;
    logic [15:0] r_start, n_start;
    logic [15:0] r_cnt, n_cnt;
    logic        drop;
    logic [8:0]  full_len;
    logic [7:0]  b;

    assign b        = i_req.request_byte;
    assign full_len = {r_len[8], b};

    always_comb begin
        n_trans = r_trans;
        n_unit  = r_unit;
        n_len   = r_len;
        n_func  = r_func;
        n_start = r_start;
        n_cnt   = r_cnt;
        drop    = 1'b0;
        case (r_pos)
            9'd0: n_trans = {b, 8'h00};
            9'd1: n_trans = {r_trans[15:8], b};
            9'd2, 9'd3: drop = (b != 8'h00);
            9'd4: begin
                drop  = (b > 8'd1);
                n_len = {b[0], 8'h00};
            end
            9'd5: begin
                drop  = (full_len < 9'd2) || (full_len > MAX_LENGTH);
                n_len = full_len;
            end
            9'd6:  n_unit  = b;
            9'd7:  n_func  = b;
            9'd8:  n_start = {b, 8'h00};
            9'd9:  n_start = {r_start[15:8], b};
            9'd10: n_cnt   = {b, 8'h00};
            9'd11: n_cnt   = {r_cnt[15:8], b};
            default: ;
        endcase
    end

    logic done;
    assign done = (r_pos >= 9'd6) && ({1'b0, r_pos} == 10'd5 + {1'b0, r_len});

    always_comb begin
        n_pos = r_pos;
        if (i_accept && !i_req.kind) begin
            if (drop || done) n_pos = '0;
            else              n_pos = r_pos + 9'd1;
        end
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.slot  = i_req.entry_slot;
        o_cmd.entry = '{unit: i_req.entry_unit, func: i_req.entry_function,
                        addr: i_req.entry_address, value: i_req.entry_value,
                        status: i_req.entry_status};
        o_cmd.trans = n_trans;
        o_cmd.unit  = n_unit;
        o_cmd.len   = n_len;
        o_cmd.func  = n_func;
        o_cmd.start = n_start;
        o_cmd.cnt   = n_cnt;
        if (i_req.kind)  o_cmd.op = CMD_MAP;
        else if (drop)   o_cmd.op = CMD_DROP;
        else             o_cmd.op = CMD_REQ;
        o_push = i_accept && (i_req.kind || drop || done);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_trans <= '0;
            r_unit  <= '0;
            r_len   <= '0;
            r_func  <= '0;
            r_start <= '0;
            r_cnt   <= '0;
        end else begin
            r_pos <= n_pos;
            if (i_accept && !i_req.kind && !drop) begin
                r_trans <= n_trans;
                r_unit  <= n_unit;
                r_len   <= n_len;
                r_func  <= n_func;
                r_start <= n_start;
                r_cnt   <= n_cnt;
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/mbtrr_queue.sv
`default_nettype none
module mbtrr_queue
    import mbtrr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cmd      o_cmd
);

    localparam int AW = $clog2(QDEPTH);

    t_cmd            r_mem [QDEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end

endmodule
`default_nettype wire

// File: rtl/mbtrr_back.sv
`default_nettype none
module mbtrr_back
    import mbtrr_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int REPLY_BYTES = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_q_empty,
    input  wire t_cmd       i_cmd,
    output logic            o_q_pop,
    input  wire logic       i_writes_enabled,
    input  wire logic [4:0] i_max_regs,
    input  wire logic [8:0] i_max_bits,
    output logic            o_empty,
    input  wire logic       i_pop,
    output t_resp           o_resp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = $clog2(REPLY_BYTES);
    localparam logic [15:0] REG_CAP = 16'((REPLY_BYTES - 9) / 2);
    localparam logic [15:0] BIT_CAP = 16'((REPLY_BYTES - 9) * 8);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_WLO  = 3'd4;
    localparam logic [2:0] S_SLD  = 3'd5;
    localparam logic [2:0] S_SHOW = 3'd6;

    logic [2:0]    r_state, n_state;
    t_cmd          r_cur;
    logic [8:0]    r_k;
    logic [SW-1:0] r_slot;
    logic [RW-1:0] r_idx;
    logic [7:0]    r_acc, r_lo, r_b7, r_b8, r_plen;
    logic          r_drop;
    logic [SLOTS-1:0] r_valid;

    t_entry        r_map [SLOTS];
    t_entry        r_mq;
    logic [7:0]    r_reply [REPLY_BYTES];
    logic [7:0]    r_rq;

    // reply store write port
    logic          rp_we;
    logic [RW-1:0] rp_wa;
    logic [7:0]    rp_wd;

    logic          map_we;
    assign map_we = (r_state == S_IDLE) && !i_q_empty && (i_cmd.op == CMD_MAP)
                    && ({1'b0, i_cmd.slot} < 7'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (map_we) r_map[i_cmd.slot[SW-1:0]] <= i_cmd.entry;
        r_mq <= r_map[r_slot];
        if (rp_we) r_reply[rp_wa] <= rp_wd;
        r_rq <= r_reply[r_idx];
    end

    // classification of the held request
    logic        is_read, is_bits, is_write;
    logic [15:0] lim;
    logic [16:0] addr;
    logic        hit, good, bitv, last_k, last_byte;
    logic [7:0]  acc_new;
    logic [5:0]  nbytes;

    always_comb begin
        is_read  = (r_cur.func == FN_READ_COILS) || (r_cur.func == FN_READ_INPUTS) ||
                   (r_cur.func == FN_READ_HOLDING) || (r_cur.func == FN_READ_INPUT_RG);
        is_bits  = (r_cur.func == FN_READ_COILS) || (r_cur.func == FN_READ_INPUTS);
        is_write = (r_cur.func == FN_WRITE_COIL) || (r_cur.func == FN_WRITE_REG) ||
                   (r_cur.func == FN_WRITE_COILS) || (r_cur.func == FN_WRITE_REGS);
        if (is_bits) lim = ({7'd0, i_max_bits} > BIT_CAP) ? BIT_CAP : {7'd0, i_max_bits};
        else         lim = ({11'd0, i_max_regs} > REG_CAP) ? REG_CAP : {11'd0, i_max_regs};
        addr   = {1'b0, r_cur.start} + {8'd0, r_k};
        hit    = r_valid[r_slot] && (r_mq.status != 2'd0) && (r_mq.unit == r_cur.unit) &&
                 ({5'd0, r_mq.func} == r_cur.func) && !addr[16] &&
                 (r_mq.addr == addr[15:0]);
        good    = (r_mq.status == 2'd1);
        bitv    = |r_mq.value;
        acc_new = r_acc | (8'(bitv) << r_k[2:0]);
        last_k  = ({7'd0, r_k} == r_cur.cnt - 16'd1);
        nbytes  = 6'((r_cur.cnt + 16'd7) >> 3);
        last_byte = (8'(r_idx) == 8'(6 + r_plen));
    end

    always_comb begin
        rp_we = 1'b0;
        rp_wa = '0;
        rp_wd = '0;
        if (r_state == S_CMP && hit && good) begin
            if (is_bits) begin
                rp_we = (r_k[2:0] == 3'd7) || last_k;
                rp_wa = RW'(10'd9 + {4'd0, r_k[8:3]});
                rp_wd = acc_new;
            end else begin
                rp_we = 1'b1;
                rp_wa = RW'(10'd9 + {r_k, 1'b0});
                rp_wd = r_mq.value[15:8];
            end
        end else if (r_state == S_WLO) begin
            rp_we = 1'b1;
            rp_wa = RW'(10'd10 + {r_k, 1'b0});
            rp_wd = r_lo;
        end
    end

    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_drop  <= 1'b0;
        end else begin
            if (map_we) r_valid[i_cmd.slot[SW-1:0]] <= 1'b1;
            r_state <= n_state;
            if (r_state == S_IDLE && !i_q_empty) r_drop <= (i_cmd.op == CMD_DROP);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_cmd.op == CMD_REQ)       n_state = S_CHK;
                    else if (i_cmd.op == CMD_DROP) n_state = S_SHOW;
                end
            end
            S_CHK: begin
                if (is_read && r_cur.len == 9'd6 && r_cur.cnt != 16'd0 && r_cur.cnt <= lim)
                    n_state = S_RD;
                else
                    n_state = S_SLD;
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                if (hit) begin
                    if (!good)        n_state = S_SLD;
                    else if (!is_bits) n_state = S_WLO;
                    else if (last_k)  n_state = S_SLD;
                    else              n_state = S_RD;
                end else if (r_slot == SW'(SLOTS - 1)) begin
                    n_state = S_SLD;
                end else begin
                    n_state = S_RD;
                end
            end
            S_WLO:  n_state = last_k ? S_SLD : S_RD;
            S_SLD:  n_state = S_SHOW;
            S_SHOW: begin
                if (i_pop) n_state = (r_drop || last_byte) ? S_IDLE : S_SLD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_cur <= i_cmd;
                r_k   <= '0;
                r_slot <= '0;
                r_idx <= '0;
                r_acc <= '0;
            end
            S_CHK: begin
                r_idx <= '0;
                if (!is_read) begin
                    r_b7   <= r_cur.func | EXC_FLAG;
                    r_b8   <= (is_write && i_writes_enabled) ? EXC_ILLEGAL_ADDRESS
                                                            : EXC_ILLEGAL_FUNCTION;
                    r_plen <= 8'd2;
                end else begin
                    r_b7   <= r_cur.func | EXC_FLAG;
                    r_b8   <= EXC_ILLEGAL_VALUE;
                    r_plen <= 8'd2;
                end
            end
            S_CMP: begin
                if (hit) begin
                    if (!good) begin
                        r_b7   <= r_cur.func | EXC_FLAG;
                        r_b8   <= EXC_DEVICE_FAILURE;
                        r_plen <= 8'd2;
                    end else if (!is_bits) begin
                        r_lo <= r_mq.value[7:0];
                    end else begin
                        r_acc  <= (r_k[2:0] == 3'd7) ? 8'd0 : acc_new;
                        r_k    <= r_k + 9'd1;
                        r_slot <= '0;
                        r_b7   <= r_cur.func;
                        r_b8   <= {2'b0, nbytes};
                        r_plen <= 8'd2 + {2'b0, nbytes};
                    end
                end else if (r_slot == SW'(SLOTS - 1)) begin
                    r_b7   <= r_cur.func | EXC_FLAG;
                    r_b8   <= EXC_ILLEGAL_ADDRESS;
                    r_plen <= 8'd2;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end
            S_WLO: begin
                r_k    <= r_k + 9'd1;
                r_slot <= '0;
                r_b7   <= r_cur.func;
                r_b8   <= 8'({r_cur.cnt[6:0], 1'b0});
                r_plen <= 8'd2 + 8'({r_cur.cnt[6:0], 1'b0});
            end
            S_SHOW: begin
                if (i_pop && !r_drop && !last_byte) r_idx <= r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    logic [7:0] hdr;
    always_comb begin
        case (r_idx)
            RW'(0):  hdr = r_cur.trans[15:8];
            RW'(1):  hdr = r_cur.trans[7:0];
            RW'(5):  hdr = r_plen + 8'd1;
            RW'(6):  hdr = r_cur.unit;
            RW'(7):  hdr = r_b7;
            RW'(8):  hdr = r_b8;
            RW'(2), RW'(3), RW'(4): hdr = 8'h00;
            default: hdr = r_rq;
        endcase
    end

    assign o_empty = (r_state != S_SHOW);
    always_comb begin
        o_resp.response_byte = r_drop ? 8'h00 : hdr;
        o_resp.response_last = !r_drop && last_byte;
        o_resp.frame_dropped = r_drop;
    end

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty && o_resp.response_last) |=> (r_state == S_IDLE))
        else $error("back end did not return to idle after last beat");
    a_drop_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_resp.frame_dropped) |-> !o_resp.response_last)
        else $error("dropped-frame beat flagged as last");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE))
        else $error("queue popped while busy");
    a_walk_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_cur.op == CMD_REQ))
        else $error("map walk without a request");

endmodule
`default_nettype wire

// File: tb/modbus_tcp_read_responder_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module modbus_tcp_read_responder_tb;
    import mbtrr_pkg::*;

    localparam int MAP_N = 64;
    localparam int REPLY_N = 64;
    localparam int REG_CAP = (REPLY_N - 9) / 2;
    localparam int BIT_CAP = (REPLY_N - 9) * 8;
    localparam int WATCHDOG = 200000;
    localparam int REQ_W = $bits(t_req);

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    t_req       i_req = '0;
    logic       empty;
    logic       pop = 1'b0;
    t_resp      o_resp;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [8:0] i_cfg_data = '0;
    logic       in_taken = 1'b0;

    modbus_tcp_read_responder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .i_req(i_req),
        .empty(empty), .pop(pop), .o_resp(o_resp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // responder shadow state
    logic       wr_en;
    logic [4:0] max_regs;
    logic [8:0] max_bits;
    int         pos;
    logic [15:0] trans;
    logic [7:0]  unit_id;
    int          flen;
    logic [7:0]  func;
    logic [15:0] start_addr;
    logic [15:0] count;
    t_entry      map_shadow [MAP_N];

    t_req  pending_items[$];
    t_resp expected_beats[$];
    int    send_idle_pct = 0, recv_idle_pct = 0;
    int    mismatches = 0, beats_seen = 0, frames_seen = 0, drops_seen = 0;
    int    items_sent = 0, quiet_cycles = 0;

    // 0 missing, 1 good, 2 failing
    function automatic int find_entry(input logic [7:0] fn, input int addr,
                                      output logic [15:0] val);
        val = '0;
        if (addr > 65535) return 0;
        for (int i = 0; i < MAP_N; i++)
            if (map_shadow[i].status != 2'd0 && map_shadow[i].unit == unit_id &&
                {5'd0, map_shadow[i].func} == fn && map_shadow[i].addr == addr[15:0]) begin
                val = map_shadow[i].value;
                return (map_shadow[i].status == 2'd1) ? 1 : 2;
            end
        return 0;
    endfunction

    task automatic emit_beat(input logic [7:0] b, input logic last, input logic dropped);
        t_resp r;
        r.response_byte = b;
        r.response_last = last;
        r.frame_dropped = dropped;
        expected_beats = {expected_beats, r};
    endtask

    task automatic build_reply();
        logic [7:0] pdu [REPLY_N];
        logic [15:0] val;
        int plen, lim, nb, st;
        logic [7:0] exc;
        plen = 0;
        exc = 8'h00;
        if (func >= FN_READ_COILS && func <= FN_READ_INPUT_RG) begin
            if (flen != 6) exc = EXC_ILLEGAL_VALUE;
            else if (func <= FN_READ_INPUTS) begin
                lim = (max_bits > BIT_CAP) ? BIT_CAP : max_bits;
                if (count == 0 || count > lim) exc = EXC_ILLEGAL_VALUE;
                else begin
                    nb = (count + 7) / 8;
                    for (int i = 0; i < REPLY_N; i++) pdu[i] = 8'h00;
                    pdu[0] = func;
                    pdu[1] = nb[7:0];
                    for (int k = 0; k < count && exc == 8'h00; k++) begin
                        st = find_entry(func, start_addr + k, val);
                        if (st == 0) exc = EXC_ILLEGAL_ADDRESS;
                        else if (st == 2) exc = EXC_DEVICE_FAILURE;
                        else if (val != 0) pdu[2 + k / 8][k % 8] = 1'b1;
                    end
                    plen = 2 + nb;
                end
            end else begin
                lim = (max_regs > REG_CAP) ? REG_CAP : max_regs;
                if (count == 0 || count > lim) exc = EXC_ILLEGAL_VALUE;
                else begin
                    pdu[0] = func;
                    pdu[1] = 8'(count * 2);
                    for (int k = 0; k < count && exc == 8'h00; k++) begin
                        st = find_entry(func, start_addr + k, val);
                        if (st == 0) exc = EXC_ILLEGAL_ADDRESS;
                        else if (st == 2) exc = EXC_DEVICE_FAILURE;
                        else begin
                            pdu[2 + 2 * k] = val[15:8];
                            pdu[3 + 2 * k] = val[7:0];
                        end
                    end
                    plen = 2 + 2 * count;
                end
            end
        end else if (func == FN_WRITE_COIL || func == FN_WRITE_REG ||
                     func == FN_WRITE_COILS || func == FN_WRITE_REGS)
            exc = wr_en ? EXC_ILLEGAL_ADDRESS : EXC_ILLEGAL_FUNCTION;
        else exc = EXC_ILLEGAL_FUNCTION;
        if (exc != 8'h00) begin
            pdu[0] = func | EXC_FLAG;
            pdu[1] = exc;
            plen = 2;
        end
        emit_beat(trans[15:8], 1'b0, 1'b0);
        emit_beat(trans[7:0], 1'b0, 1'b0);
        emit_beat(8'h00, 1'b0, 1'b0);
        emit_beat(8'h00, 1'b0, 1'b0);
        emit_beat(8'((plen + 1) >> 8), 1'b0, 1'b0);
        emit_beat(8'(plen + 1), 1'b0, 1'b0);
        emit_beat(unit_id, 1'b0, 1'b0);
        for (int i = 0; i < plen; i++) emit_beat(pdu[i], i == plen - 1, 1'b0);
    endtask

    task automatic predict_item(input t_req it);
        logic [7:0] b;
        bit dropped;
        if (it.kind) begin
            map_shadow[it.entry_slot] = '{it.entry_unit, it.entry_function,
                                          it.entry_address, it.entry_value,
                                          it.entry_status};
            return;
        end
        b = it.request_byte;
        dropped = 0;
        case (pos)
            0: trans[15:8] = b;
            1: trans[7:0] = b;
            2, 3: dropped = (b != 0);
            4: if (b > 1) dropped = 1; else flen = b << 8;
            5: begin
                if ((flen | b) < 2 || (flen | b) > MAX_LENGTH) dropped = 1;
                else flen = flen | b;
            end
            6: unit_id = b;
            7: func = b;
            8: start_addr[15:8] = b;
            9: start_addr[7:0] = b;
            10: count[15:8] = b;
            11: count[7:0] = b;
            default: ;
        endcase
        if (dropped) begin
            pos = 0;
            emit_beat(8'h00, 1'b0, 1'b1);
        end else if (pos >= 6 && pos == 5 + flen) begin
            pos = 0;
            build_reply();
        end else pos = (pos + 1) & 9'h1FF;
    endtask

    function automatic t_req map_item(input int slot, input logic [7:0] u, input logic [2:0] f,
                                      input logic [15:0] a, input logic [15:0] v,
                                      input logic [1:0] s);
        t_req it;
        it = '0;
        it.kind = 1'b1;
        it.request_byte = 8'($urandom);
        it.entry_slot = 6'(slot);
        it.entry_unit = u;
        it.entry_function = f;
        it.entry_address = a;
        it.entry_value = v;
        it.entry_status = s;
        return it;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        t_req it;
        it = t_req'(REQ_W'({$urandom, $urandom}));
        it.kind = 1'b0;
        it.request_byte = b;
        pending_items = {pending_items, it};
    endtask

    // full frame: header with given length, then pdu bytes (pad to len-1)
    task automatic queue_frame(input logic [15:0] tid, input logic [7:0] u, input int len,
                               input logic [7:0] fn, input logic [15:0] a,
                               input logic [15:0] c);
        logic [7:0] pdu_b [5];
        pdu_b = '{fn, a[15:8], a[7:0], c[15:8], c[7:0]};
        queue_byte(tid[15:8]);
        queue_byte(tid[7:0]);
        queue_byte(8'h00);
        queue_byte(8'h00);
        queue_byte(8'(len >> 8));
        queue_byte(8'(len));
        queue_byte(u);
        for (int i = 0; i < len - 1; i++) queue_byte(i < 5 ? pdu_b[i] : 8'($urandom));
    endtask

    // driver: in_taken tells whether the beat on the port went in at the last edge
    always @(negedge i_clk) begin
        if (i_rst_n && (!push || in_taken)) begin
            if (push) items_sent <= items_sent + 1;
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                push <= 1'b1;
                i_req <= pending_items.pop_front();
            end else push <= 1'b0;
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        in_taken <= push && !full;
        if (i_rst_n) begin
            if (push && !full) predict_item(i_req);
            if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (pop && !empty) begin
                beats_seen <= beats_seen + 1;
                if (expected_beats.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected beat %p", o_resp);
                end else begin
                    t_resp e;
                    e = expected_beats.pop_front();
                    if (e.frame_dropped) drops_seen <= drops_seen + 1;
                    if (e.response_last) frames_seen <= frames_seen + 1;
                    if (o_resp !== e) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("beat mismatch: expected byte %h last %b drop %b, got %h %b %b",
                                     e.response_byte, e.response_last, e.frame_dropped,
                                     o_resp.response_byte, o_resp.response_last,
                                     o_resp.frame_dropped);
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || push || expected_beats.size() > 0)
            @(posedge i_clk);
        repeat (2 * MAP_N * 30 + 200) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [8:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_WRITES_ENABLED: wr_en = d[0];
            CFG_MAX_REGS: max_regs = d[4:0];
            CFG_MAX_BITS: max_bits = d;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random traffic: mostly mapped reads over a small address window
    task automatic random_phase(input int n_items);
        int start_n;
        logic [7:0] fn;
        start_n = pending_items.size();
        while (pending_items.size() - start_n < n_items) begin
            case ($urandom_range(9))
                0, 1: pending_items = {pending_items, map_item($urandom_range(63),
                          8'($urandom_range(2)), 3'($urandom_range(1, 4)),
                          16'($urandom_range(0, 12)), 16'($urandom),
                          2'($urandom_range(0, 9) == 0 ? 2 + $urandom_range(1)
                                                       : $urandom_range(1)))};
                2: queue_byte(8'($urandom));
                3: begin
                    fn = 8'($urandom);
                    queue_frame(16'($urandom), 8'($urandom_range(2)), $urandom_range(2, 9),
                                fn, 16'($urandom), 16'($urandom));
                end
                default: begin
                    fn = 8'($urandom_range(1, 4));
                    queue_frame(16'($urandom), 8'($urandom_range(2)), 6, fn,
                                16'($urandom_range(0, 12)),
                                16'($urandom_range(0, 9) == 0 ? $urandom_range(0, 500)
                                    : $urandom_range(1, 6)));
                end
            endcase
        end
    endtask

    initial begin
        wr_en = 1'b0; max_regs = 5'd27; max_bits = 9'd440;
        pos = 0; trans = '0; unit_id = '0; flen = 0; func = '0;
        start_addr = '0; count = '0;
        foreach (map_shadow[i]) map_shadow[i] = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 8; recv_idle_pct = 61;

        // directed: edges of the map, every read function, header drops
        pending_items = {pending_items,
                         map_item(0, 8'h01, 3'd3, 16'hFFFF, 16'hA55A, 2'd1),
                         map_item(63, 8'h01, 3'd3, 16'hFFFF, 16'h1234, 2'd1),
                         map_item(1, 8'hFF, 3'd1, 16'h0000, 16'h0001, 2'd1),
                         map_item(2, 8'hFF, 3'd2, 16'h0000, 16'h0000, 2'd2),
                         map_item(3, 8'hFF, 3'd4, 16'h0000, 16'hFFFF, 2'd3)};
        queue_frame(16'hFFFF, 8'h01, 6, FN_READ_HOLDING, 16'hFFFF, 16'd1);
        queue_frame(16'h0000, 8'h01, 6, FN_READ_HOLDING, 16'hFFFF, 16'd2);
        queue_frame(16'h1234, 8'hFF, 6, FN_READ_COILS, 16'h0000, 16'd1);
        queue_frame(16'h1235, 8'hFF, 6, FN_READ_INPUTS, 16'h0000, 16'd1);
        queue_frame(16'h1236, 8'hFF, 6, FN_READ_INPUT_RG, 16'h0000, 16'd1);
        queue_frame(16'h1237, 8'hFF, 6, FN_READ_COILS, 16'h0000, 16'd0);
        queue_frame(16'h1238, 8'hFF, 7, FN_READ_COILS, 16'h0000, 16'd1);
        queue_frame(16'h1239, 8'hFF, 2, FN_WRITE_REG, 16'h0, 16'h0);
        queue_frame(16'h123A, 8'hFF, 260, 8'h2B, 16'h0, 16'h0);
        queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h01);  // protocol drop
        queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h02);
        wait_drained();

        write_cfg(CFG_WRITES_ENABLED, 9'd1);
        write_cfg(CFG_MAX_REGS, 9'd31);
        write_cfg(CFG_MAX_BITS, 9'd511);
        queue_frame(16'hABCD, 8'h00, 6, FN_WRITE_COILS, 16'h0, 16'h0);
        queue_frame(16'hABCE, 8'h00, 6, FN_READ_HOLDING, 16'h0, 16'd28);
        queue_frame(16'hABCF, 8'h00, 6, FN_READ_COILS, 16'h0, 16'd441);
        random_phase(20);
        wait_drained();

        send_idle_pct = 61; recv_idle_pct = 8;
        write_cfg(CFG_WRITES_ENABLED, 9'd0);
        write_cfg(CFG_MAX_REGS, 9'd1);
        write_cfg(CFG_MAX_BITS, 9'd1);
        random_phase(20);
        wait_drained();

        send_idle_pct = 0; recv_idle_pct = 0;
        write_cfg(CFG_MAX_REGS, 9'd4);
        write_cfg(CFG_MAX_BITS, 9'd5);
        random_phase(20);
        wait_drained();

        $display("Sent %0d items; checked %0d beats in %0d frames and %0d drops.",
                 items_sent, beats_seen, frames_seen, drops_seen);
        $display("Covered map loads, all read functions, exceptions and three limit settings.");
        if (mismatches == 0 && expected_beats.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
